// File: rtl/lome_pkg.sv
// ----------------------------------------------------------------------------
// lome_pkg - shared types for the limit order matching engine
// Slot count, field widths, result kinds, sequencer states and the request
// carried to the shared priority compare unit.
// ----------------------------------------------------------------------------
package lome_pkg;

	localparam int ORDER_SLOTS = 32;
	localparam int SLOT_W      = $clog2(ORDER_SLOTS);
	localparam int CNT_W       = $clog2(ORDER_SLOTS + 1);
	localparam int IN_W        = 168;
	localparam int OUT_W       = 264;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_CANCEL = 1'b1;
	localparam logic SIDE_BUY    = 1'b0;
	localparam logic SIDE_SELL   = 1'b1;

	typedef enum logic [2:0] {
		KIND_TRADE      = 3'd0,
		KIND_ADD_DONE   = 3'd1,
		KIND_DUPLICATE  = 3'd2,
		KIND_BOOK_FULL  = 3'd3,
		KIND_CANCEL_OK  = 3'd4,
		KIND_NOT_FOUND  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ID_SCAN,
		ST_MATCH_CHK,
		ST_BEST_SCAN,
		ST_TRADE,
		ST_FREE_SCAN,
		ST_STAT_SCAN,
		ST_STATUS
	} state_t;

	// one candidate-against-best decision
	typedef struct packed {
		logic        side;       // 1: asks, lowest wins
		logic        best_valid;
		logic [31:0] cand_price;
		logic [31:0] best_price;
		logic [31:0] cand_age;
		logic [31:0] best_age;
	} cmp_req_t;

endpackage

// File: rtl/lome_cmp.sv
// ----------------------------------------------------------------------------
// lome_cmp - price-time priority compare
// Decides whether the scanned slot beats the best order held so far.
// ----------------------------------------------------------------------------
module lome_cmp
	import lome_pkg::*;
(
	input  cmp_req_t req,
	output logic     better
);

	logic price_better;

	// better price first, then the older order at equal price
	always_comb begin
		price_better = req.side ? (req.cand_price < req.best_price)
		                        : (req.cand_price > req.best_price);
		if (!req.best_valid) begin
			better = 1'b1;
		end else if (req.cand_price != req.best_price) begin
			better = price_better;
		end else begin
			better = req.cand_age > req.best_age;
		end
	end

endmodule

// File: rtl/limit_order_matching_engine.sv
// ----------------------------------------------------------------------------
// limit_order_matching_engine - price-time priority order book
// Sequencer stepping one slot a cycle through a 32-entry book, sharing one
// priority compare unit for every best-order search.
// ----------------------------------------------------------------------------
// channel  dir  payload                                  marks
// s_*      in   order request, 168-bit tdata             tuser = func
// m_*      out  trade / status result, 264-bit tdata     tuser = kind, tlast
//
// Every request starts with an id scan over all slots. A cancel or
// duplicate then takes a status scan and the status step. An add steps
// through the match check, a best-order scan and the trade step for each
// fill partner; a search that finds none at a crossing price, or a filled
// quantity, ends matching, and a resting remainder adds a free-slot scan.
// s_tready is high only when idle; trade and status steps stall until the
// output register is free. Reset clears the used flags and arrival counter.
module limit_order_matching_engine
	import lome_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// ord_id[31:0] side[32] order_type[33] limit_price[65:34]
	// order_qty[97:66] arrival_time[161:98], zero pad above
	input  logic [IN_W-1:0]  s_tdata,
	// func
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// buyer_id[31:0] seller_id[63:32] fill_price[95:64] trade_qty[127:96]
	// fill_time[191:128] top_bid[223:192] top_bid_valid[224]
	// top_ask[256:225] top_ask_valid[257] resting_count[263:258]
	output logic [OUT_W-1:0] m_tdata,
	// kind
	output logic [2:0]       m_tuser,
	output logic             m_tlast
);

	// slot store
	logic [ORDER_SLOTS-1:0] used_q;
	logic                   side_a_q  [ORDER_SLOTS];
	logic [31:0]            price_a_q [ORDER_SLOTS];
	logic [31:0]            rem_a_q   [ORDER_SLOTS];
	logic [31:0]            id_a_q    [ORDER_SLOTS];
	logic [31:0]            seq_a_q   [ORDER_SLOTS];
	logic [31:0]            counter_q;

	state_t state_q, state_d;

	// latched request
	logic        func_q, side_q, mkt_q;
	logic [31:0] oid_q, lp_q, qty_q;
	logic [63:0] time_q;

	// scan registers
	logic [SLOT_W-1:0] idx_q, fidx_q, bidx_q, free_idx_q;
	logic              found_q, bv_q, free_v_q;
	logic [31:0]       bprice_q, bage_q, brem_q, bid_q;
	logic              sb_v_q, sa_v_q;
	logic [31:0]       sb_p_q, sa_p_q;
	logic [CNT_W-1:0]  cnt_q;
	kind_t             kind_q;

	logic              scan_last, out_free, accept, issue;
	logic [SLOT_W-1:0] idx_nxt;
	logic              c_used, c_side;
	logic [31:0]       c_price, c_rem, c_id, c_age, fill;
	logic              mk, better;
	cmp_req_t          creq;

	assign scan_last = idx_q == SLOT_W'(ORDER_SLOTS - 1);
	assign idx_nxt   = scan_last ? '0 : idx_q + SLOT_W'(1);
	assign out_free  = !m_tvalid || m_tready;
	assign s_tready  = state_q == ST_IDLE;
	assign accept    = s_tvalid && s_tready;

	// current slot under the scan pointer
	assign c_used  = used_q[idx_q];
	assign c_side  = side_a_q[idx_q];
	assign c_price = price_a_q[idx_q];
	assign c_rem   = rem_a_q[idx_q];
	assign c_id    = id_a_q[idx_q];
	assign c_age   = counter_q - seq_a_q[idx_q];

	assign fill = (qty_q < brem_q) ? qty_q : brem_q;
	assign mk   = mkt_q || ((side_q == SIDE_BUY) ? (bprice_q <= lp_q) : (bprice_q >= lp_q));

	// a trade or the status item enters the output register
	assign issue = out_free && ((state_q == ST_TRADE && bv_q && mk) || state_q == ST_STATUS);

	// shared priority compare, opposite side of the incoming order
	always_comb begin
		creq.side       = ~side_q;
		creq.best_valid = bv_q;
		creq.cand_price = c_price;
		creq.best_price = bprice_q;
		creq.cand_age   = c_age;
		creq.best_age   = bage_q;
	end

	lome_cmp u_cmp (
		.req    (creq),
		.better (better)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_ID_SCAN;
			end
			ST_ID_SCAN: begin
				if (scan_last) begin
					if (func_q == FUNC_CANCEL || found_q ||
					    (c_used && c_id == oid_q)) begin
						state_d = ST_STAT_SCAN;
					end else begin
						state_d = ST_MATCH_CHK;
					end
				end
			end
			ST_MATCH_CHK: begin
				if (qty_q == 32'd0) begin
					state_d = ST_STAT_SCAN;
				end else begin
					state_d = ST_BEST_SCAN;
				end
			end
			ST_BEST_SCAN: begin
				if (scan_last) begin
					// final candidate folded in on this edge; decision next
					state_d = ST_TRADE;
				end
			end
			ST_TRADE: begin
				if (!bv_q || !mk) begin
					state_d = (mkt_q || qty_q == 32'd0) ? ST_STAT_SCAN : ST_FREE_SCAN;
				end else if (out_free) begin
					state_d = ST_MATCH_CHK;
				end
			end
			ST_FREE_SCAN: begin
				if (scan_last) state_d = ST_STAT_SCAN;
			end
			ST_STAT_SCAN: begin
				if (scan_last) state_d = ST_STATUS;
			end
			ST_STATUS: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers: used flags, counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			counter_q <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			if (issue) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_ID_SCAN: begin
					if (scan_last && func_q == FUNC_CANCEL) begin
						if (c_used && c_id == oid_q) used_q[idx_q] <= 1'b0;
						else if (found_q) used_q[fidx_q] <= 1'b0;
					end
				end
				ST_TRADE: begin
					if (bv_q && mk && out_free) begin
						if (brem_q == fill) used_q[bidx_q] <= 1'b0;
					end
				end
				ST_FREE_SCAN: begin
					if (scan_last && (free_v_q || !c_used)) begin
						used_q[free_v_q ? free_idx_q : idx_q] <= 1'b1;
						counter_q <= counter_q + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// slot payload and scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q   <= '0;
				found_q <= 1'b0;
				func_q  <= s_tuser;
				oid_q   <= s_tdata[31:0];
				side_q  <= s_tdata[32];
				mkt_q   <= s_tdata[33];
				lp_q    <= s_tdata[65:34];
				qty_q   <= s_tdata[97:66];
				time_q  <= s_tdata[161:98];
			end
			ST_ID_SCAN: begin
				idx_q <= idx_nxt;
				if (c_used && c_id == oid_q) begin
					found_q <= 1'b1;
					fidx_q  <= idx_q;
				end
				if (scan_last) begin
					sb_v_q <= 1'b0;
					sa_v_q <= 1'b0;
					cnt_q  <= '0;
					if (func_q == FUNC_CANCEL) begin
						kind_q <= (found_q || (c_used && c_id == oid_q)) ?
						          KIND_CANCEL_OK : KIND_NOT_FOUND;
					end else begin
						kind_q <= KIND_DUPLICATE;
					end
				end
			end
			ST_MATCH_CHK: begin
				idx_q    <= '0;
				bv_q     <= 1'b0;
				free_v_q <= 1'b0;
				sb_v_q   <= 1'b0;
				sa_v_q   <= 1'b0;
				cnt_q    <= '0;
				kind_q   <= KIND_ADD_DONE;
			end
			ST_BEST_SCAN: begin
				idx_q <= idx_nxt;
				if (c_used && c_side != side_q && better) begin
					bv_q     <= 1'b1;
					bidx_q   <= idx_q;
					bprice_q <= c_price;
					bage_q   <= c_age;
					brem_q   <= c_rem;
					bid_q    <= c_id;
				end
			end
			ST_TRADE: begin
				idx_q <= '0;
				if (bv_q && mk && out_free) begin
					qty_q           <= qty_q - fill;
					rem_a_q[bidx_q] <= brem_q - fill;
					m_tuser         <= KIND_TRADE;
					m_tlast         <= 1'b0;
					m_tdata         <= {72'd0, time_q, fill, bprice_q,
					                    (side_q == SIDE_BUY) ? bid_q : oid_q,
					                    (side_q == SIDE_BUY) ? oid_q : bid_q};
				end
			end
			ST_FREE_SCAN: begin
				idx_q <= idx_nxt;
				if (!c_used && !free_v_q) begin
					free_v_q   <= 1'b1;
					free_idx_q <= idx_q;
				end
				if (scan_last) begin
					if (free_v_q || !c_used) begin
						side_a_q[free_v_q ? free_idx_q : idx_q]  <= side_q;
						price_a_q[free_v_q ? free_idx_q : idx_q] <= lp_q;
						rem_a_q[free_v_q ? free_idx_q : idx_q]   <= qty_q;
						id_a_q[free_v_q ? free_idx_q : idx_q]    <= oid_q;
						seq_a_q[free_v_q ? free_idx_q : idx_q]   <= counter_q;
					end else begin
						kind_q <= KIND_BOOK_FULL;
					end
				end
			end
			ST_STAT_SCAN: begin
				idx_q <= idx_nxt;
				if (c_used) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (c_side == SIDE_BUY) begin
						if (!sb_v_q || c_price > sb_p_q) begin
							sb_v_q <= 1'b1;
							sb_p_q <= c_price;
						end
					end else begin
						if (!sa_v_q || c_price < sa_p_q) begin
							sa_v_q <= 1'b1;
							sa_p_q <= c_price;
						end
					end
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					m_tuser <= kind_q;
					m_tlast <= 1'b1;
					m_tdata <= {6'(cnt_q), sa_v_q, sa_v_q ? sa_p_q : 32'd0,
					            sb_v_q, sb_v_q ? sb_p_q : 32'd0, 192'd0};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// a trade is never the closing item
	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_TRADE |-> !m_tlast)
		else $error("trade item marked last");

	// a taken request starts the id scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_ID_SCAN)
		else $error("request not followed by id scan");

	// issuing the status item raises a last-marked result
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STATUS && out_free |=> m_tvalid && m_tlast)
		else $error("status item not presented");

	// no request is taken while the best-order scan is under way
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BEST_SCAN |-> !s_tready)
		else $error("ready during scan");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for the limit order matching engine
// Drives add and cancel requests on the order stream, predicts every trade
// and status result with a behavioural copy of the book, and checks each
// result field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
	import lome_pkg::*;

	localparam int WATCHDOG  = 20000;
	localparam int EXP_DEPTH = 4096;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [2:0]       m_tuser;
	logic             m_tlast;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] buyer_id;
		logic [31:0] seller_id;
		logic [31:0] fill_price;
		logic [31:0] trade_qty;
		logic [63:0] fill_time;
		logic [31:0] top_bid;
		logic        top_bid_valid;
		logic [31:0] top_ask;
		logic        top_ask_valid;
		logic [5:0]  resting_count;
		logic        last;
	} book_result_t;

	// behavioural book
	logic        bk_used [ORDER_SLOTS];
	logic        bk_side [ORDER_SLOTS];
	logic [31:0] bk_price[ORDER_SLOTS];
	logic [31:0] bk_rem  [ORDER_SLOTS];
	logic [31:0] bk_id   [ORDER_SLOTS];
	logic [31:0] bk_seq  [ORDER_SLOTS];
	logic [31:0] bk_counter;

	// expected results, written by the predictor, read by the checker
	book_result_t exp_q [EXP_DEPTH];
	int  exp_wr, exp_rd;
	int  errors;
	int  n_sent, n_trades, n_results;
	int  idle_cycles;
	bit  gaps_on;
	bit  hold_rx;
	int  hold_len;
	int  rx_gap;

	limit_order_matching_engine dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	function automatic void exp_push(book_result_t r);
		exp_q[exp_wr[11:0]] = r;
		exp_wr++;
	endfunction

	function automatic int book_find_id(logic [31:0] id);
		for (int i = 0; i < ORDER_SLOTS; i++)
			if (bk_used[i] && bk_id[i] == id) return i;
		return -1;
	endfunction

	// best price on one side, oldest first within a price
	function automatic int book_best(logic s);
		int b;
		b = -1;
		for (int i = 0; i < ORDER_SLOTS; i++) begin
			if (!bk_used[i] || bk_side[i] != s) continue;
			if (b < 0) b = i;
			else if (bk_price[i] != bk_price[b]) begin
				if (s ? (bk_price[i] < bk_price[b]) : (bk_price[i] > bk_price[b])) b = i;
			end else if (32'(bk_counter - bk_seq[i]) > 32'(bk_counter - bk_seq[b]))
				b = i;
		end
		return b;
	endfunction

	function automatic book_result_t book_status(kind_t k);
		book_result_t r;
		int bb, ba;
		r = '0;
		bb = book_best(SIDE_BUY);
		ba = book_best(SIDE_SELL);
		r.kind = k;
		if (bb >= 0) begin
			r.top_bid = bk_price[bb];
			r.top_bid_valid = 1'b1;
		end
		if (ba >= 0) begin
			r.top_ask = bk_price[ba];
			r.top_ask_valid = 1'b1;
		end
		for (int i = 0; i < ORDER_SLOTS; i++) r.resting_count += 6'(bk_used[i]);
		r.last = 1'b1;
		return r;
	endfunction

	// work out the results one order request causes
	task automatic predict_book(logic func, logic [31:0] id, logic sd, logic mkt,
			logic [31:0] lp, logic [31:0] qty, logic [63:0] t);
		int k, b, fs;
		logic [31:0] f;
		book_result_t r;
		if (func == FUNC_CANCEL) begin
			k = book_find_id(id);
			if (k < 0) exp_push(book_status(KIND_NOT_FOUND));
			else begin
				bk_used[k] = 1'b0;
				exp_push(book_status(KIND_CANCEL_OK));
			end
			return;
		end
		if (book_find_id(id) >= 0) begin
			exp_push(book_status(KIND_DUPLICATE));
			return;
		end
		while (qty > 0) begin
			b = book_best(~sd);
			if (b < 0) break;
			if (!(mkt || (sd == SIDE_BUY ? bk_price[b] <= lp : bk_price[b] >= lp))) break;
			f = qty < bk_rem[b] ? qty : bk_rem[b];
			r = '0;
			r.kind = KIND_TRADE;
			r.buyer_id = sd == SIDE_BUY ? id : bk_id[b];
			r.seller_id = sd == SIDE_BUY ? bk_id[b] : id;
			r.fill_price = bk_price[b];
			r.trade_qty = f;
			r.fill_time = t;
			exp_push(r);
			qty -= f;
			bk_rem[b] -= f;
			if (bk_rem[b] == 0) bk_used[b] = 1'b0;
		end
		if (!mkt && qty > 0) begin
			fs = -1;
			for (int i = 0; i < ORDER_SLOTS; i++)
				if (!bk_used[i]) begin
					fs = i;
					break;
				end
			if (fs < 0) begin
				exp_push(book_status(KIND_BOOK_FULL));
				return;
			end
			bk_used[fs] = 1'b1;
			bk_side[fs] = sd;
			bk_price[fs] = lp;
			bk_rem[fs] = qty;
			bk_id[fs] = id;
			bk_seq[fs] = bk_counter;
			bk_counter++;
		end
		exp_push(book_status(KIND_ADD_DONE));
	endtask

	// send one request, predict it once accepted; valid stays up between requests unless a random gap drops it
	task automatic send_order(logic func, logic [31:0] id, logic sd, logic mkt,
			logic [31:0] lp, logic [31:0] qty, logic [63:0] t);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {6'b0, t, qty, lp, mkt, sd, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_book(func, id, sd, mkt, lp, qty, t);
		n_sent++;
	endtask

	task automatic put_add(logic [31:0] id, logic sd, logic mkt, logic [31:0] lp,
			logic [31:0] qty);
		send_order(FUNC_ADD, id, sd, mkt, lp, qty, {$urandom, $urandom});
	endtask

	task automatic put_cancel(logic [31:0] id);
		send_order(FUNC_CANCEL, id, 1'($urandom), 1'($urandom), $urandom, $urandom,
			{$urandom, $urandom});
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// result receiver: short random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_len <= 0;
			rx_gap   <= 0;
		end else if (hold_rx && hold_len == 0) begin
			hold_len <= 600;
			m_tready <= 1'b0;
		end else if (hold_len > 1) begin
			hold_len <= hold_len - 1;
			m_tready <= 1'b0;
		end else if (hold_len == 1) begin
			hold_len <= -1;
			m_tready <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap   <= rx_gap - 1;
			m_tready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			rx_gap   <= $urandom_range(1, 6) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		book_result_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = '0;
			got.kind = m_tuser;
			{got.resting_count, got.top_ask_valid, got.top_ask, got.top_bid_valid,
				got.top_bid, got.fill_time, got.trade_qty, got.fill_price,
				got.seller_id, got.buyer_id} = m_tdata;
			got.last = m_tlast;
			n_results++;
			if (exp_wr == exp_rd) begin
				$error("unexpected result kind %0d", got.kind);
				errors++;
			end else begin
				exp_r = exp_q[exp_rd[11:0]];
				exp_rd++;
				if (got.kind == KIND_TRADE) n_trades++;
				if (got.kind != exp_r.kind) begin
					$error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++; end
				if (got.buyer_id != exp_r.buyer_id) begin
					$error("buyer_id exp %0h got %0h", exp_r.buyer_id, got.buyer_id); errors++; end
				if (got.seller_id != exp_r.seller_id) begin
					$error("seller_id exp %0h got %0h", exp_r.seller_id, got.seller_id);
					errors++; end
				if (got.fill_price != exp_r.fill_price) begin
					$error("fill_price exp %0h got %0h", exp_r.fill_price, got.fill_price);
					errors++; end
				if (got.trade_qty != exp_r.trade_qty) begin
					$error("trade_qty exp %0h got %0h", exp_r.trade_qty, got.trade_qty);
					errors++; end
				if (got.fill_time != exp_r.fill_time) begin
					$error("fill_time exp %0h got %0h", exp_r.fill_time, got.fill_time);
					errors++; end
				if (got.top_bid != exp_r.top_bid) begin
					$error("top_bid exp %0h got %0h", exp_r.top_bid, got.top_bid); errors++; end
				if (got.top_bid_valid != exp_r.top_bid_valid) begin
					$error("top_bid_valid exp %0d got %0d", exp_r.top_bid_valid,
						got.top_bid_valid); errors++; end
				if (got.top_ask != exp_r.top_ask) begin
					$error("top_ask exp %0h got %0h", exp_r.top_ask, got.top_ask); errors++; end
				if (got.top_ask_valid != exp_r.top_ask_valid) begin
					$error("top_ask_valid exp %0d got %0d", exp_r.top_ask_valid,
						got.top_ask_valid); errors++; end
				if (got.resting_count != exp_r.resting_count) begin
					$error("resting_count exp %0d got %0d", exp_r.resting_count,
						got.resting_count); errors++; end
				if (got.last != exp_r.last) begin
					$error("last exp %0d got %0d", exp_r.last, got.last); errors++; end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("tb: errors");
			$finish;
		end
	end

	// extremes of every field and each special case
	task automatic test_directed();
		put_add(32'hFFFF_FFFF, SIDE_SELL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		put_add(32'h0, SIDE_BUY, 1'b0, 32'h0, 32'd5);
		put_add(32'hFFFF_FFFF, SIDE_BUY, 1'b0, 32'd9, 32'd1);      // duplicate id
		put_add(32'd10, SIDE_BUY, 1'b0, 32'd50, 32'd0);            // zero quantity
		put_add(32'd11, SIDE_SELL, 1'b0, 32'd100, 32'd10);
		put_add(32'd12, SIDE_SELL, 1'b0, 32'd100, 32'd10);         // same price, younger
		put_add(32'd13, SIDE_BUY, 1'b0, 32'd100, 32'd15);          // oldest first
		put_add(32'd14, SIDE_BUY, 1'b1, 32'd0, 32'd100);           // market, filled across both asks
		put_add(32'd15, SIDE_SELL, 1'b1, 32'hFFFF_FFFF, 32'd3);    // market sell into bid 0
		put_add(32'd16, SIDE_BUY, 1'b0, 32'd200, 32'd7);
		put_add(32'd17, SIDE_SELL, 1'b0, 32'd150, 32'd20);         // sell takes bid, rests
		put_cancel(32'd17);
		put_cancel(32'd17);                                       // not resting
		put_cancel(32'hFFFF_FFFF);
		put_add(32'd18, SIDE_SELL, 1'b1, 32'd0, 32'd1);            // market sell, fills against bid 0
		drain_results();
	endtask

	// fill all slots, reject a resting remainder, trade against the full book, then cancel the filler orders
	task automatic test_book_full();
		int free_cnt;
		free_cnt = 0;
		for (int i = 0; i < ORDER_SLOTS; i++) free_cnt += !bk_used[i];
		for (int i = 0; i < free_cnt; i++)
			put_add(32'h1000 + i, SIDE_BUY, 1'b0, 32'd1 + i % 4, 32'd2);
		put_add(32'h2000, SIDE_BUY, 1'b0, 32'd3, 32'd1);
		put_add(32'h2001, SIDE_SELL, 1'b0, 32'd4, 32'd1);
		put_add(32'h2002, SIDE_SELL, 1'b0, 32'd1, 32'd1);          // takes the oldest bid at 4
		drain_results();
		for (int i = 0; i < ORDER_SLOTS; i++) put_cancel(32'h1000 + i);
		drain_results();
	endtask

	// random well-formed flow around a mid price, with some noise
	task automatic test_random(int count);
		logic [31:0] id, lp, qty;
		logic sd, mkt;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			id = $urandom_range(0, 3) == 0 ? $urandom : 32'h5000 + $urandom_range(0, 40);
			sd = 1'($urandom);
			mkt = $urandom_range(0, 9) == 0;
			lp = 32'd1000 + $urandom_range(0, 20) - 10;
			qty = $urandom_range(1, 30);
			if (r < 4) put_cancel(id);
			else if (r == 4) send_order(1'($urandom), $urandom, 1'($urandom), 1'($urandom),
				$urandom, $urandom, {$urandom, $urandom});
			else put_add(id, sd, mkt, lp, qty);
		end
	endtask

	// receiver held off while the sender keeps offering
	task automatic test_backpressure();
		hold_rx <= 1'b1;
		test_random(10);
		hold_rx <= 1'b0;
		drain_results();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		hold_rx = 1'b0;
		errors = 0;
		n_sent = 0;
		n_trades = 0;
		n_results = 0;
		idle_cycles = 0;
		exp_wr = 0;
		exp_rd = 0;
		gaps_on = 1'b1;
		for (int i = 0; i < ORDER_SLOTS; i++) bk_used[i] = 1'b0;
		bk_counter = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_book_full();
		test_backpressure();
		test_random(100);
		drain_results();
		gaps_on = 1'b0;
		test_random(40);
		drain_results();
		$display("tb: %0d requests, %0d results, %0d trades", n_sent, n_results, n_trades);
		$display("tb: covered duplicates, cancels, market orders, full book and stalls");
		if (errors == 0 && exp_wr == exp_rd) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
